>>> hw/rtl/nrmc_pkg.sv
package nrmc_pkg;

	localparam int unsigned LINE_BUFFER = 128;
	localparam int unsigned MAX_TOKENS  = 12;
	localparam int unsigned MIN_TOKENS  = 9;
	localparam int unsigned FRAC_DIGITS = 5;

	localparam int unsigned POS_W   = 8;
	localparam int unsigned TOK_W   = 4;
	localparam int unsigned WHOLE_W = 17;
	localparam int unsigned FRAC_W  = 17;
	localparam int unsigned FCNT_W  = 3;
	localparam int unsigned COORD_W = 35;
	localparam int unsigned MAG_W   = 34;

	localparam logic [WHOLE_W-1:0] WHOLE_MAX = 17'd99999;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_W     = 8'h57;

	typedef struct packed {
		logic [WHOLE_W-1:0] whole;
		logic [FRAC_W-1:0]  frac;
		logic [FCNT_W-1:0]  fcnt;
	} num_t;

	typedef struct packed {
		logic       parsed;
		logic       fix_ok;
		logic [1:0] neg;
		num_t [1:0] num;
	} rec_t;

	function automatic logic [7:0] prefix_char(input logic [2:0] idx);
		logic [7:0] r;
		case (idx)
			3'd0: r = 8'h24;
			3'd1: r = 8'h47;
			3'd2: r = 8'h50;
			3'd3: r = 8'h52;
			3'd4: r = 8'h4D;
			3'd5: r = 8'h43;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [FRAC_W-1:0] frac_scale(input logic [FCNT_W-1:0] cnt);
		logic [FRAC_W-1:0] r;
		case (cnt)
			3'd0: r = 17'd100000;
			3'd1: r = 17'd10000;
			3'd2: r = 17'd1000;
			3'd3: r = 17'd100;
			3'd4: r = 17'd10;
			default: r = 17'd1;
		endcase
		return r;
	endfunction

endpackage

>>> hw/rtl/nrmc_front.sv
module nrmc_front
	import nrmc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,
	input  logic       s_axis_tlast,
	input  logic       q_full,
	output logic       q_push,
	output rec_t       q_rec
);

	localparam logic [TOK_W-1:0] TOK_STATUS = 4'd2;
	localparam logic [TOK_W-1:0] TOK_LAT    = 4'd3;
	localparam logic [TOK_W-1:0] TOK_NS     = 4'd4;
	localparam logic [TOK_W-1:0] TOK_LON    = 4'd5;
	localparam logic [TOK_W-1:0] TOK_EW     = 4'd6;

	typedef struct packed {
		num_t val;
		logic point;
		logic stopped;
	} nst_t;

	function automatic nst_t num_step(input nst_t s, input logic [7:0] c);
		nst_t r;
		logic [19:0] w;
		logic [3:0] d;
		r = s;
		d = 4'(c - CH_ZERO);
		w = 20'(s.val.whole) * 20'd10 + 20'(d);
		if (!s.stopped) begin
			if (c >= CH_ZERO && c <= CH_NINE) begin
				if (!s.point) begin
					r.val.whole = (w > 20'(WHOLE_MAX)) ? WHOLE_MAX : w[WHOLE_W-1:0];
				end else if (s.val.fcnt < FCNT_W'(FRAC_DIGITS)) begin
					r.val.frac = FRAC_W'(s.val.frac * FRAC_W'(10) + FRAC_W'(d));
					r.val.fcnt = s.val.fcnt + 3'd1;
				end
			end else if (c == CH_POINT && !s.point) begin
				r.point = 1'b1;
			end else begin
				r.stopped = 1'b1;
			end
		end
		return r;
	endfunction

	logic [POS_W-1:0] bpos_q, n_bpos;
	logic             prefix_q, n_prefix;
	logic             ended_q, n_ended;
	logic [TOK_W-1:0] tok_q, n_tok;
	logic             inside_q, n_inside;
	logic [1:0]       tlen_q, n_tlen;
	logic             status_q, n_status;
	logic             south_q, n_south;
	logic             west_q, n_west;
	nst_t [1:0]       num_q, n_num;
	logic             accept;
	logic [TOK_W:0]   count;

	assign s_axis_tready = !q_full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_comb begin
		logic [7:0] c;
		logic [1:0] tl;
		c        = s_axis_tdata;
		tl       = 2'd0;
		n_bpos   = (bpos_q < POS_W'(LINE_BUFFER)) ? bpos_q + 8'd1 : bpos_q;
		n_prefix = prefix_q;
		n_ended  = ended_q;
		n_tok    = tok_q;
		n_inside = inside_q;
		n_tlen   = tlen_q;
		n_status = status_q;
		n_south  = south_q;
		n_west   = west_q;
		n_num    = num_q;
		if (!ended_q) begin
			if (bpos_q < 8'd6 && c != prefix_char(bpos_q[2:0])) begin
				n_prefix = 1'b0;
			end
			if (c == CH_NUL) begin
				n_ended = 1'b1;
			end else if (bpos_q < POS_W'(LINE_BUFFER - 1)) begin
				if (c == CH_COMMA) begin
					if (inside_q) begin
						if (tok_q < TOK_W'(MAX_TOKENS)) begin
							n_tok = tok_q + 4'd1;
						end
						n_inside = 1'b0;
					end
				end else begin
					tl       = inside_q ? tlen_q : 2'd0;
					n_inside = 1'b1;
					n_tlen   = tl;
					if (tok_q < TOK_W'(MAX_TOKENS)) begin
						case (tok_q)
							TOK_STATUS: n_status = (tl == 2'd0) && (c == CH_A);
							TOK_NS:     n_south = (tl == 2'd0) && (c == CH_S);
							TOK_EW:     n_west = (tl == 2'd0) && (c == CH_W);
							TOK_LAT:    n_num[0] = num_step(num_q[0], c);
							TOK_LON:    n_num[1] = num_step(num_q[1], c);
							default: ;
						endcase
						if (tl != 2'd3) begin
							n_tlen = tl + 2'd1;
						end
					end
				end
			end
		end
	end

	assign count = {1'b0, n_tok} + {4'd0, n_inside};

	always_comb begin
		logic ok;
		ok = n_prefix && (n_bpos >= 8'd6) && (count >= (TOK_W+1)'(MIN_TOKENS));
		q_push          = accept && s_axis_tlast;
		q_rec.parsed    = ok;
		q_rec.fix_ok    = ok && n_status;
		q_rec.neg       = {n_west, n_south};
		q_rec.num[0]    = n_num[0].val;
		q_rec.num[1]    = n_num[1].val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpos_q   <= '0;
			prefix_q <= 1'b1;
			ended_q  <= 1'b0;
			tok_q    <= '0;
			inside_q <= 1'b0;
			tlen_q   <= '0;
			status_q <= 1'b0;
			south_q  <= 1'b0;
			west_q   <= 1'b0;
			num_q    <= '0;
		end else if (accept) begin
			if (s_axis_tlast) begin
				bpos_q   <= '0;
				prefix_q <= 1'b1;
				ended_q  <= 1'b0;
				tok_q    <= '0;
				inside_q <= 1'b0;
				tlen_q   <= '0;
				status_q <= 1'b0;
				south_q  <= 1'b0;
				west_q   <= 1'b0;
				num_q    <= '0;
			end else begin
				bpos_q   <= n_bpos;
				prefix_q <= n_prefix;
				ended_q  <= n_ended;
				tok_q    <= n_tok;
				inside_q <= n_inside;
				tlen_q   <= n_tlen;
				status_q <= n_status;
				south_q  <= n_south;
				west_q   <= n_west;
				num_q    <= n_num;
			end
		end
	end

endmodule

>>> hw/rtl/nrmc_queue.sv
module nrmc_queue
	import nrmc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rec_t push_rec,
	output logic full,
	input  logic pop,
	output logic empty,
	output rec_t head_rec
);

	rec_t       mem_q [4];
	logic [1:0] wptr_q;
	logic [1:0] rptr_q;
	logic [2:0] cnt_q;
	logic       do_pop;

	assign full     = (cnt_q == 3'd4);
	assign empty    = (cnt_q == 3'd0);
	assign do_pop   = pop && !empty;
	assign head_rec = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 2'd1;
			end
			if (do_pop) begin
				rptr_q <= rptr_q + 2'd1;
			end
			cnt_q <= cnt_q + {2'd0, push} - {2'd0, do_pop};
		end
	end

endmodule

>>> hw/rtl/nrmc_back.sv
module nrmc_back
	import nrmc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  rec_t        q_head,
	output logic        q_pop,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata
);

	localparam logic [17:0] RECIP_100 = 18'd167773;
	localparam logic [25:0] RECIP_3   = 26'd44739243;

	logic en;

	logic             v_s1, v_s2, v_s3, v_s4, out_valid_q;
	logic             ok_s1, ok_s2, ok_s3, ok_s4;
	logic             fix_s1, fix_s2, fix_s3, fix_s4;
	logic [1:0]       neg_s1, neg_s2, neg_s3, neg_s4;
	logic [1:0][9:0]  q_s1;
	logic [1:0][16:0] w_s1;
	logic [1:0][16:0] fs_s1, fs_s2;
	logic [1:0][6:0]  r_s2;
	logic [1:0][33:0] dd_s2, dd_s3, dd_s4;
	logic [1:0][25:0] x_s3;
	logic [1:0][51:0] p_s4;
	logic [1:0][COORD_W-1:0] coord_q;
	logic             ok_q, fix_q;

	assign en    = !out_valid_q || m_axis_tready;
	assign q_pop = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= !q_empty;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		logic [33:0] qp;
		logic [33:0] fp;
		logic [16:0] rd;
		logic [MAG_W-1:0] mag;
		if (en) begin
			ok_s1  <= q_head.parsed;
			fix_s1 <= q_head.fix_ok;
			neg_s1 <= q_head.neg;
			ok_s2  <= ok_s1;
			fix_s2 <= fix_s1;
			neg_s2 <= neg_s1;
			ok_s3  <= ok_s2;
			fix_s3 <= fix_s2;
			neg_s3 <= neg_s2;
			ok_s4  <= ok_s3;
			fix_s4 <= fix_s3;
			neg_s4 <= neg_s3;
			ok_q   <= ok_s4;
			fix_q  <= fix_s4;
			for (int k = 0; k < 2; k++) begin
				qp       = 34'(q_head.num[k].whole) * 34'(RECIP_100);
				q_s1[k]  <= qp[33:24];
				w_s1[k]  <= q_head.num[k].whole;
				fp       = 34'(q_head.num[k].frac) * 34'(frac_scale(q_head.num[k].fcnt));
				fs_s1[k] <= fp[16:0];

				rd       = w_s1[k] - 17'(q_s1[k]) * 17'd100;
				r_s2[k]  <= rd[6:0];
				dd_s2[k] <= 34'(q_s1[k]) * 34'd10000000;
				fs_s2[k] <= fs_s1[k];

				x_s3[k]  <= 26'(r_s2[k]) * 26'd500000 + 26'(fs_s2[k]) * 26'd5;
				dd_s3[k] <= dd_s2[k];

				p_s4[k]  <= 52'(x_s3[k]) * 52'(RECIP_3);
				dd_s4[k] <= dd_s3[k];

				mag = dd_s4[k] + MAG_W'(p_s4[k][51:27]);
				if (!fix_s4) begin
					coord_q[k] <= '0;
				end else if (neg_s4[k]) begin
					coord_q[k] <= COORD_W'(0) - {1'b0, mag};
				end else begin
					coord_q[k] <= {1'b0, mag};
				end
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {coord_q[1], coord_q[0], fix_q, ok_q};

endmodule

>>> hw/rtl/nmea_rmc_position_parser.sv
// Channel   Direction  tdata (low bit first)                          tlast
// s_axis    in         ch[7:0]                                          last
// m_axis    out        parsed, fix_ok, latitude[34:0], longitude[34:0]  always 1
//
// One sentence byte is taken per cycle while the queue has room; a result passes
// through the queue and the conversion stages before it is presented on m_axis. The
// tokenizer front end feeds a four-entry record queue, and a five-stage conversion
// pipeline behind it drains one record per cycle while the output is not held.
// Reset clears all sentence state, the queue and the pipeline valids.
// The input stalls only while the queue is full; the pipeline stalls only while the
// output transaction is held by m_axis_tready low.
module nmea_rmc_position_parser
	import nrmc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // ch
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,  // parsed, fix_ok, latitude, longitude
	output logic        m_axis_tlast
);

	logic q_full;
	logic q_push;
	logic q_pop;
	logic q_empty;
	rec_t q_rec;
	rec_t q_head;

	assign m_axis_tlast = 1'b1;

	nrmc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_rec         (q_rec)
	);

	nrmc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_rec (q_rec),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head_rec (q_head)
	);

	nrmc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

>>> verif/testbench.sv
module testbench;
	import nrmc_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned TAIL_CYCLES    = 20;
	localparam int unsigned STALL_CYCLES   = 300;
	localparam logic [47:0] RMC_HEADER     = "$GPRMC";

	typedef struct packed {
		logic               parsed;
		logic               fix;
		logic [COORD_W-1:0] lat;
		logic [COORD_W-1:0] lon;
	} fix_rec_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [71:0] m_axis_tdata;
	logic        m_axis_tlast;

	nmea_rmc_position_parser dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	fix_rec_t    fix_q[$];
	fix_rec_t    want;
	logic [7:0]  line_buf[$];
	int          errors;
	int          bytes_in;
	int          fixes_made;
	int          fixes_seen;
	int          quiet_cycles;
	int          snd_idle_pct;
	int          rcv_stall_pct;
	bit          stall_request;
	int          stall_left;

	// Sentence state of the position predictor.
	int unsigned byte_cnt;
	bit          hdr_ok;
	bit          text_done;
	int unsigned tok_cnt;
	bit          in_tok;
	int unsigned tok_chars;
	bit          fix_active;
	bit          is_south;
	bit          is_west;
	int unsigned num_int[2];
	int unsigned num_frac[2];
	int unsigned num_fcnt[2];
	bit          num_point[2];
	bit          num_halt[2];

	initial begin
		clk = 1'b0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void clear_sentence();
		byte_cnt   = 0;
		hdr_ok     = 1'b1;
		text_done  = 1'b0;
		tok_cnt    = 0;
		in_tok     = 1'b0;
		tok_chars  = 0;
		fix_active = 1'b0;
		is_south   = 1'b0;
		is_west    = 1'b0;
		for (int k = 0; k < 2; k++) begin
			num_int[k]   = 0;
			num_frac[k]  = 0;
			num_fcnt[k]  = 0;
			num_point[k] = 1'b0;
			num_halt[k]  = 1'b0;
		end
	endfunction

	function automatic void take_number_byte(input int k, input logic [7:0] c);
		int unsigned w;
		if (num_halt[k])
			return;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			if (!num_point[k]) begin
				w = num_int[k] * 10 + (c - CH_ZERO);
				num_int[k] = (w > WHOLE_MAX) ? WHOLE_MAX : w;
			end else if (num_fcnt[k] < FRAC_DIGITS) begin
				num_frac[k] = num_frac[k] * 10 + (c - CH_ZERO);
				num_fcnt[k]++;
			end
		end else if (c == CH_POINT && !num_point[k]) begin
			num_point[k] = 1'b1;
		end else begin
			num_halt[k] = 1'b1;
		end
	endfunction

	// ddmm.mmmmm to degrees in units of 1e-7, truncated, as a 35-bit two's complement.
	function automatic logic [COORD_W-1:0] coord_units(input int k, input bit neg);
		longint unsigned scale;
		longint unsigned fs;
		longint unsigned mins;
		longint unsigned mag;
		scale = 1;
		for (int i = 0; i < FRAC_DIGITS; i++)
			scale = scale * 10;
		fs = num_frac[k];
		for (int i = num_fcnt[k]; i < FRAC_DIGITS; i++)
			fs = fs * 10;
		mins = longint'(num_int[k] % 100) * scale + fs;
		mag = longint'(num_int[k] / 100) * 64'd10000000 + (mins * 64'd10000000) / (60 * scale);
		if (neg)
			mag = -mag;
		return mag[COORD_W-1:0];
	endfunction

	function automatic void predict_byte(input logic [7:0] c, input logic is_last);
		int unsigned pos;
		int unsigned cnt;
		bit          ok;
		bit          fix;
		fix_rec_t    r;
		pos = byte_cnt;
		if (byte_cnt < LINE_BUFFER)
			byte_cnt++;
		if (!text_done) begin
			if (pos < 6 && c != RMC_HEADER[8*(5-pos) +: 8])
				hdr_ok = 1'b0;
			if (c == CH_NUL) begin
				text_done = 1'b1;
			end else if (pos < LINE_BUFFER - 1) begin
				if (c == CH_COMMA) begin
					if (in_tok) begin
						if (tok_cnt < MAX_TOKENS)
							tok_cnt++;
						in_tok = 1'b0;
					end
				end else begin
					if (!in_tok) begin
						in_tok = 1'b1;
						tok_chars = 0;
					end
					if (tok_cnt < MAX_TOKENS) begin
						case (tok_cnt)
							2: fix_active = (tok_chars == 0) && (c == CH_A);
							3: take_number_byte(0, c);
							4: is_south = (tok_chars == 0) && (c == CH_S);
							5: take_number_byte(1, c);
							6: is_west = (tok_chars == 0) && (c == CH_W);
							default: ;
						endcase
						if (tok_chars < 3)
							tok_chars++;
					end
				end
			end
		end
		if (is_last) begin
			cnt = tok_cnt + (in_tok ? 1 : 0);
			if (cnt > MAX_TOKENS)
				cnt = MAX_TOKENS;
			ok = hdr_ok && byte_cnt >= 6 && cnt >= MIN_TOKENS;
			fix = ok && fix_active;
			r.parsed = ok;
			r.fix    = fix;
			r.lat    = fix ? coord_units(0, is_south) : '0;
			r.lon    = fix ? coord_units(1, is_west) : '0;
			fix_q.push_back(r);
			fixes_made++;
			clear_sentence();
		end
	endfunction

	task automatic send_byte(input logic [7:0] c, input logic is_last);
		while ($urandom_range(99) < snd_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		s_axis_tlast  <= is_last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_byte(c, is_last);
		bytes_in++;
		@(negedge clk);
	endtask

	task automatic send_line();
		for (int i = 0; i < line_buf.size(); i++)
			send_byte(line_buf[i], i == line_buf.size() - 1);
		line_buf.delete();
	endtask

	task automatic add_str(input string s);
		for (int i = 0; i < s.len(); i++)
			line_buf.push_back(s[i]);
	endtask

	task automatic send_text(input string s);
		add_str(s);
		send_line();
	endtask

	task automatic add_digits(input int n);
		repeat (n)
			line_buf.push_back(CH_ZERO + 8'($urandom_range(9)));
	endtask

	task automatic add_coord();
		int nw;
		nw = ($urandom_range(99) < 80) ? $urandom_range(4, 5) : $urandom_range(0, 8);
		add_digits(nw);
		if ($urandom_range(99) < 85) begin
			line_buf.push_back(CH_POINT);
			add_digits($urandom_range(0, 7));
		end
		if ($urandom_range(99) < 8)
			line_buf.push_back(8'($urandom_range(33, 126)));
	endtask

	task automatic build_random_line();
		int nf;
		int pick;
		if ($urandom_range(99) < 10) begin
			repeat ($urandom_range(1, 12))
				line_buf.push_back(8'($urandom_range(255)));
			return;
		end
		pick = $urandom_range(99);
		if (pick < 85) begin
			add_str("$GPRMC");
		end else if (pick < 92) begin
			add_str("$GPGGA");
		end else begin
			add_str("$GP");
			repeat (3)
				line_buf.push_back(CH_A + 8'($urandom_range(25)));
		end
		nf = $urandom_range(6, 14);
		for (int f = 1; f <= nf; f++) begin
			line_buf.push_back(CH_COMMA);
			if ($urandom_range(99) < 8)
				line_buf.push_back(CH_COMMA);
			pick = $urandom_range(99);
			case (f)
				1: begin
					if (pick >= 10) begin
						add_digits(6);
						add_str(".00");
					end
				end
				2: begin
					if (pick < 70)
						add_str("A");
					else if (pick < 85)
						add_str("V");
					else if (pick < 92)
						add_str("AV");
				end
				3, 5: add_coord();
				4: add_str(pick < 45 ? "N" : (pick < 90 ? "S" : "SX"));
				6: add_str(pick < 45 ? "E" : (pick < 90 ? "W" : "WW"));
				default: add_digits($urandom_range(0, 4));
			endcase
		end
		if ($urandom_range(99) < 4) begin
			line_buf.push_back(CH_COMMA);
			repeat ($urandom_range(60, 120))
				line_buf.push_back(8'($urandom_range(33, 126)));
		end
		if ($urandom_range(99) < 4)
			line_buf[$urandom_range(6, line_buf.size() - 1)] = CH_NUL;
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (fix_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic test_well_formed();
		send_text("$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W*6A");
		send_text("$GPRMC,081836,A,3751.65,S,14507.36,W,000.0,360.0,130998,011.3,E*62");
		send_text("$GPRMC,0,A,0000.00000,N,00000.00000,E,0,0");
		send_text("$GPRMC,1,A,9959.99999,S,17959.99999,W,1,2");
		send_text("$GPRMC,,123519,,A,4807.038,,N,01131.000,E,,1,2");
	endtask

	task automatic test_rejected();
		send_text("$GPR");
		send_text("$GPGGA,123519,A,4807.038,N,01131.000,E,1,2,3");
		send_text("$gprmc,123519,A,4807.038,N,01131.000,E,1,2,3");
		send_text("$GPRMC,1,A,4807.038,N,01131.000,E,1");
		send_text("$GPRMC,225446,V,4916.45,N,12311.12,W,000.5,054.7,191194,020.3,E*68");
		send_text("$GPRMC,225446,AA,4916.45,N,12311.12,W,000.5,054.7");
		send_text("$GPRMC,1,A,1,N,1,E,1,2,3,4,5,6,7,8,9,10");
		send_byte(8'hFF, 1'b1);
		send_byte(CH_NUL, 1'b1);
	endtask

	task automatic test_number_forms();
		send_text("$GPRMC,1,A,1234567.1234567,S,99999999.999999,W,1,2");
		send_text("$GPRMC,1,A,4807.0e5,N,-12.5,E,1,2");
		send_text("$GPRMC,1,A,12.3.4,SS,4807,WW,1,2");
		send_text("$GPRMC,1,A,.5,S,4807.,W,1,2");
	endtask

	task automatic test_text_limits();
		// The tenth token starts past the tokenized part of the line.
		add_str("$GPRMC,1,A,4807.038,S,01131.000,W,1,");
		repeat (100)
			line_buf.push_back(CH_NINE);
		add_str(",2");
		send_line();
		// Digits of a second latitude-like number straddle the end of the tokenized part.
		add_str("$GPRMC,1,A,4807.038,S,1,W,1,2,3,");
		repeat (85)
			line_buf.push_back(CH_ZERO);
		add_str(",A,4807.1234,N,01131.1234,E");
		send_line();
		add_str("$GPRMC,1,A,4807.038,N,0113");
		line_buf.push_back(CH_NUL);
		send_text("1.000,E,1,2,3");
		add_str("$GPRMC,1,A,4807.038,N,01131.000,E,1,2");
		line_buf.push_back(CH_NUL);
		send_text("77,88");
		add_str("$GPRMC,1,A,4807.038,N,01131.000,E,1,2");
		line_buf.push_back(CH_NUL);
		send_line();
	endtask

	task automatic test_random_traffic(input int snd_pct, input int rcv_pct,
		input int min_bytes, input int min_results);
		int b0;
		int r0;
		snd_idle_pct  = snd_pct;
		rcv_stall_pct = rcv_pct;
		b0 = bytes_in;
		r0 = fixes_made;
		while (bytes_in - b0 < min_bytes || fixes_made - r0 < min_results) begin
			build_random_line();
			send_line();
		end
	endtask

	// Short sentences pile up behind a held output until the input stalls.
	task automatic test_output_backpressure();
		snd_idle_pct  = 0;
		rcv_stall_pct = 0;
		stall_request = 1'b1;
		repeat (14) begin
			if ($urandom_range(3) != 0)
				send_byte(8'($urandom_range(255)), 1'b1);
			else
				send_text("$GPRMC,1,A,4807.038,N,01131.000,E,1,2");
		end
		wait_drained();
	endtask

	always @(negedge clk) begin
		if (stall_request) begin
			stall_left = STALL_CYCLES;
			stall_request = 1'b0;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (fix_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h",
					$time, m_axis_tdata);
				errors++;
			end else begin
				want = fix_q.pop_front();
				fixes_seen++;
				if (m_axis_tdata[0] !== want.parsed) begin
					$display("%0t: parsed mismatch, expected %0d, actual %0d",
						$time, want.parsed, m_axis_tdata[0]);
					errors++;
				end
				if (m_axis_tdata[1] !== want.fix) begin
					$display("%0t: fix_ok mismatch, expected %0d, actual %0d",
						$time, want.fix, m_axis_tdata[1]);
					errors++;
				end
				if (m_axis_tdata[36:2] !== want.lat) begin
					$display("%0t: latitude mismatch, expected %0d, actual %0d",
						$time, $signed(want.lat), $signed(m_axis_tdata[36:2]));
					errors++;
				end
				if (m_axis_tdata[71:37] !== want.lon) begin
					$display("%0t: longitude mismatch, expected %0d, actual %0d",
						$time, $signed(want.lon), $signed(m_axis_tdata[71:37]));
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		m_axis_tready = 1'b0;
		errors        = 0;
		bytes_in      = 0;
		fixes_made    = 0;
		fixes_seen    = 0;
		quiet_cycles  = 0;
		snd_idle_pct  = 0;
		rcv_stall_pct = 0;
		stall_request = 1'b0;
		stall_left    = 0;
		clear_sentence();
		repeat (7)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_well_formed();
		test_rejected();
		test_number_forms();
		test_text_limits();
		test_random_traffic(0, 0, 40, 1);
		test_random_traffic(66, 0, 40, 1);
		test_random_traffic(0, 66, 40, 1);
		test_random_traffic(32, 32, 40, 1);
		test_output_backpressure();

		while (fix_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES)
			@(posedge clk);

		$display("Sent %0d sentence bytes and checked %0d position results.", bytes_in, fixes_seen);
		$display("Covered four idle mixes on both sides and one long output hold-off.");
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
